FILE: sv/htmc_pkg.sv
// Shared types, constants and a helper function for the trixel ID converter.
package htmc_pkg;

   localparam int MAX_LEVEL     = 24;
   localparam int DEC_MAX_LEVEL = 17;
   localparam int BCD_DIGITS    = 20;
   localparam int DEC_TERMS     = DEC_MAX_LEVEL + 2;
   localparam int STEPS_PER_STG = 8;
   localparam int DABBLE_STAGES = 64 / STEPS_PER_STG;

   localparam logic OP_BIN_TO_DEC = 1'b0;
   localparam logic OP_DEC_TO_BIN = 1'b1;

   localparam logic [63:0] POW10 [0:18] = '{
      64'd1, 64'd10, 64'd100, 64'd1000, 64'd10000, 64'd100000, 64'd1000000,
      64'd10000000, 64'd100000000, 64'd1000000000, 64'd10000000000,
      64'd100000000000, 64'd1000000000000, 64'd10000000000000,
      64'd100000000000000, 64'd1000000000000000, 64'd10000000000000000,
      64'd100000000000000000, 64'd1000000000000000000
   };

   typedef struct packed {
      logic        opcode;
      logic [63:0] value;
   } req_type;

   typedef struct packed {
      logic [63:0] result;
      logic [4:0]  level;
      logic        invalid;
      logic        digit_warning;
   } rsp_type;

   typedef struct packed {
      logic                       op;
      logic [63:0]                value;
      logic [63:0]                sh;
      logic [4*BCD_DIGITS-1:0]    bcd;
      logic [5:0]                 top;
      logic [4:0]                 lvl;
      logic                       ok;
      logic [4:0][63:0]           psum;
      logic [63:0]                sum;
   } pipe_type;

   function automatic pipe_type dabble_step(input pipe_type p);
      pipe_type                q;
      logic [4*BCD_DIGITS-1:0] b;
      q = p;
      b = p.bcd;
      for (int j = 0; j < BCD_DIGITS; j++) begin
         if (b[4*j +: 4] >= 4'd5) begin
            b[4*j +: 4] = b[4*j +: 4] + 4'd3;
         end
      end
      q.bcd = {b[4*BCD_DIGITS-2:0], p.sh[63]};
      q.sh  = {p.sh[62:0], 1'b0};
      return q;
   endfunction

endpackage

FILE: sv/htmc_dabble_stage.sv
// One pipeline stage that runs eight shift-and-add-3 steps of the binary to BCD conversion.
module htmc_dabble_stage import htmc_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  pipe_type in_data,
   output logic     out_valid,
   input  logic     out_ready,
   output pipe_type out_data
);

   logic     valid_ff;
   pipe_type data_ff;
   pipe_type data_in;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      data_in = in_data;
      for (int s = 0; s < STEPS_PER_STG; s++) begin
         data_in = dabble_step(data_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

FILE: sv/htm_id_level_and_decimal_convert_top.sv
// Top level of the trixel ID converter between binary and decimal forms.
//
// Requests arrive on req_valid/req_stall/req_data; a transfer happens on a
// clock edge where req_valid is high and req_stall is low. Opcode 0 turns a
// binary trixel ID into its level and decimal form; opcode 1 turns a decimal
// form back into a binary ID.
// Results leave on rsp_valid/rsp_stall/rsp_data with one result per request,
// in request order.
// The pipeline has nine register stages: eight stages of eight BCD steps each
// carry the 64-bit binary to BCD conversion, and a final stage forms the
// result.
// Throughput is one request per cycle while the receiver does not stall.
// When rsp_stall is high the result holds, stages fill up behind it one by
// one, and req_stall rises once every stage is occupied.
// Synchronous reset empties every stage; no result is pending afterwards.
module htm_id_level_and_decimal_convert_top import htmc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   pipe_type st_in  [DABBLE_STAGES];
   pipe_type st_out [DABBLE_STAGES];
   logic     v_in   [DABBLE_STAGES];
   logic     v_out  [DABBLE_STAGES];
   logic     r_in   [DABBLE_STAGES];
   logic     r_out  [DABBLE_STAGES];

   logic     fin_valid_ff;
   rsp_type  fin_data_ff;
   rsp_type  fin_data_in;
   logic     fin_ready;

   for (genvar g = 0; g < DABBLE_STAGES; g++) begin : g_stage
      htmc_dabble_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (v_in[g]),
         .in_ready  (r_in[g]),
         .in_data   (st_in[g]),
         .out_valid (v_out[g]),
         .out_ready (r_out[g]),
         .out_data  (st_out[g])
      );
   end

   assign fin_ready = !fin_valid_ff || !rsp_stall;
   assign req_stall = !r_in[0];
   assign rsp_valid = fin_valid_ff;
   assign rsp_data  = fin_data_ff;

   always_comb begin
      v_in[0] = req_valid;
      for (int i = 0; i < DABBLE_STAGES - 1; i++) begin
         v_in[i+1] = v_out[i];
         r_out[i]  = r_in[i+1];
      end
      r_out[DABBLE_STAGES-1] = fin_ready;
   end

   always_comb begin
      logic [1:0]  d;
      logic [63:0] term;
      pipe_type    p;

      p        = '0;
      p.op     = req_data.opcode;
      p.value  = req_data.value;
      p.sh     = req_data.value;
      for (int i = 0; i < 64; i++) begin
         if (req_data.value[i]) begin
            p.top = 6'(i);
         end
      end
      st_in[0] = p;

      p     = st_out[0];
      p.lvl = 5'((p.top - 6'd3) >> 1);
      p.ok  = (p.value >= 64'd8) && !p.value[63] && p.top[0]
              && (p.top <= 6'(2 * MAX_LEVEL + 3));
      p.psum = '0;
      for (int k = 0; k < DEC_TERMS; k++) begin
         d = p.value[2*k +: 2];
         if (5'(k) == p.lvl + 5'd1) begin
            d = d - 2'd1;
         end
         term = 64'(d) * POW10[k];
         p.psum[k >> 2] = p.psum[k >> 2] + term;
      end
      st_in[1] = p;

      p         = st_out[1];
      p.psum[0] = st_out[1].psum[0] + st_out[1].psum[1] + st_out[1].psum[2];
      p.psum[1] = st_out[1].psum[3] + st_out[1].psum[4];
      st_in[2]  = p;

      p        = st_out[2];
      p.sum    = st_out[2].psum[0] + st_out[2].psum[1];
      st_in[3] = p;

      for (int i = 4; i < DABBLE_STAGES; i++) begin
         st_in[i] = st_out[i-1];
      end
   end

   always_comb begin
      pipe_type    p;
      logic        dec_ok;
      logic [4:0]  n;
      logic [3:0]  lead_d;
      logic [3:0]  lead;
      logic [63:0] low;
      logic        warn;

      p      = st_out[DABBLE_STAGES-1];
      dec_ok = p.ok && (p.lvl <= 5'(DEC_MAX_LEVEL));
      n      = '0;
      low    = '0;
      warn   = 1'b0;
      for (int k = 0; k < BCD_DIGITS; k++) begin
         if (p.bcd[4*k +: 4] != 4'd0) begin
            n = 5'(k);
         end
      end
      for (int k = 0; k < BCD_DIGITS; k++) begin
         if (5'(k) < n) begin
            low[2*k +: 2] = p.bcd[4*k +: 2];
            if (p.bcd[4*k +: 4] > 4'd3) begin
               warn = 1'b1;
            end
         end
      end
      lead_d = p.bcd[{n, 2'b00} +: 4];
      lead   = {1'b0, lead_d[2:0]} + 4'd1;

      fin_data_in = '0;
      case (p.op)
         OP_BIN_TO_DEC: begin
            fin_data_in.result  = dec_ok ? p.sum : 64'd0;
            fin_data_in.level   = p.ok ? p.lvl : 5'd0;
            fin_data_in.invalid = !dec_ok;
         end
         OP_DEC_TO_BIN: begin
            fin_data_in.result        = (64'(lead) << {n, 1'b0}) | low;
            fin_data_in.digit_warning = warn;
         end
         default: begin
            fin_data_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_valid_ff <= 1'b0;
      end else if (fin_ready) begin
         fin_valid_ff <= v_out[DABBLE_STAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      if (fin_ready && v_out[DABBLE_STAGES-1]) begin
         fin_data_ff <= fin_data_in;
      end
   end

endmodule

FILE: sv/htmc_checker.sv
// Port-level checks for the trixel ID converter and their binding to the top level.
module htmc_checker import htmc_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid && !req_stall)
      else $error("A result is pending or the input is stalled right after reset.");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("A stalled result changed or vanished.");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.invalid |-> rsp_data.result == 64'd0
         && !rsp_data.digit_warning)
      else $error("A rejected ID produced a nonzero result or a warning.");

   a_warn_decimal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.digit_warning |-> !rsp_data.invalid
         && rsp_data.level == 5'd0)
      else $error("A digit warning came with binary-side fields set.");

endmodule

bind htm_id_level_and_decimal_convert_top htmc_checker u_checker (.*);

FILE: sim/tb.sv
// Self-checking testbench for the trixel ID converter with a built-in predictor.
module tb import htmc_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   rsp_type conv_queue[$];
   int      err_count;
   int      send_idle_pct;
   int      recv_stall_pct;

   htm_id_level_and_decimal_convert_top u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   function automatic rsp_type convert_id(input req_type rq);
      rsp_type     r;
      logic [63:0] v;
      logic [63:0] id;
      logic [63:0] factor;
      logic [63:0] t;
      logic [63:0] bin;
      logic [3:0]  digs[20];
      int          top;
      int          lv;
      int          n;
      r = '0;
      v = rq.value;
      if (rq.opcode == OP_BIN_TO_DEC) begin
         if (v < 64'd8 || v[63]) begin
            r.invalid = 1'b1;
         end else begin
            top = 63;
            while (top > 0 && !v[top]) top--;
            lv = top - 3;
            if (lv[0] || lv > 2 * MAX_LEVEL) begin
               r.invalid = 1'b1;
            end else begin
               lv = lv / 2;
               r.level = lv[4:0];
               if (lv > DEC_MAX_LEVEL) begin
                  r.invalid = 1'b1;
               end else begin
                  id = v;
                  factor = 64'd1;
                  for (int k = 0; k <= lv; k++) begin
                     r.result += factor * id[1:0];
                     id = id >> 2;
                     factor *= 64'd10;
                  end
                  r.result += id[0] ? 2 * factor : factor;
               end
            end
         end
      end else begin
         n = 0;
         t = v;
         do begin
            digs[n] = 4'(t % 64'd10);
            n++;
            t = t / 64'd10;
         end while (t != 0 && n < 20);
         bin = '0;
         for (int k = n - 1; k >= 0; k--) begin
            bin = bin << 2;
            if (k == n - 1) begin
               bin = (bin | digs[k][2:0]) + 64'd1;
            end else begin
               if (digs[k] > 4'd3) r.digit_warning = 1'b1;
               bin = bin | digs[k][1:0];
            end
         end
         r.result = bin;
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch %s: got %h expected %h", what, got, want);
      err_count++;
   endtask

   task automatic send_id(input logic op, input logic [63:0] v);
      req_type rq;
      rq.opcode = op;
      rq.value = v;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= rq;
      conv_queue.push_back(convert_id(rq));
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   always @(posedge clock) begin
      rsp_type w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (conv_queue.size() == 0) begin
            report_mismatch("unexpected transfer", rsp_data.result, 64'd0);
         end else begin
            w = conv_queue.pop_front();
            if (rsp_data.result !== w.result)
               report_mismatch("result", rsp_data.result, w.result);
            if (rsp_data.level !== w.level)
               report_mismatch("level", 64'(rsp_data.level), 64'(w.level));
            if (rsp_data.invalid !== w.invalid)
               report_mismatch("invalid", 64'(rsp_data.invalid), 64'(w.invalid));
            if (rsp_data.digit_warning !== w.digit_warning)
               report_mismatch("digit_warning", 64'(rsp_data.digit_warning),
                               64'(w.digit_warning));
         end
      end
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   function automatic logic [63:0] good_bin(input int lv);
      logic [63:0] v;
      v = rand64() & ((64'd1 << (2 * lv + 3)) - 1);
      return v | (64'd1 << (2 * lv + 3));
   endfunction

   function automatic logic [63:0] rand_dec();
      logic [63:0] d;
      int          n;
      n = $urandom_range(1, 20);
      d = $urandom_range(9);
      for (int k = 1; k < n; k++)
         d = d * 10 + ($urandom_range(3) == 0 ? $urandom_range(9) : $urandom_range(3));
      return d;
   endfunction

   task automatic test_bin_directed();
      send_id(OP_BIN_TO_DEC, 64'd0);
      send_id(OP_BIN_TO_DEC, 64'd7);
      send_id(OP_BIN_TO_DEC, 64'd8);
      send_id(OP_BIN_TO_DEC, 64'd15);
      send_id(OP_BIN_TO_DEC, 64'd16);
      send_id(OP_BIN_TO_DEC, 64'h8000_0000_0000_0000);
      send_id(OP_BIN_TO_DEC, 64'hFFFF_FFFF_FFFF_FFFF);
      send_id(OP_BIN_TO_DEC, 64'h7FFF_FFFF_FFFF_FFFF);
      send_id(OP_BIN_TO_DEC, good_bin(MAX_LEVEL));
      send_id(OP_BIN_TO_DEC, good_bin(DEC_MAX_LEVEL));
      send_id(OP_BIN_TO_DEC, good_bin(DEC_MAX_LEVEL + 1));
      send_id(OP_BIN_TO_DEC, (64'd1 << (2 * MAX_LEVEL + 5)) | 64'd5);
      send_id(OP_BIN_TO_DEC, (64'd1 << 38) - 1);
   endtask

   task automatic test_dec_directed();
      send_id(OP_DEC_TO_BIN, 64'd0);
      send_id(OP_DEC_TO_BIN, 64'd9);
      send_id(OP_DEC_TO_BIN, 64'd8);
      send_id(OP_DEC_TO_BIN, 64'd1);
      send_id(OP_DEC_TO_BIN, 64'd23);
      send_id(OP_DEC_TO_BIN, 64'd29);
      send_id(OP_DEC_TO_BIN, 64'd10333);
      send_id(OP_DEC_TO_BIN, 64'hFFFF_FFFF_FFFF_FFFF);
      send_id(OP_DEC_TO_BIN, 64'd13333333333333333333);
      send_id(OP_DEC_TO_BIN, 64'd1000000000000000000);
   endtask

   task automatic test_random(input int count);
      int          pick;
      logic [63:0] v;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(9);
         if (pick < 4) begin
            send_id(OP_BIN_TO_DEC, good_bin($urandom_range(DEC_MAX_LEVEL)));
         end else if (pick == 4) begin
            send_id(OP_BIN_TO_DEC, good_bin($urandom_range(MAX_LEVEL)));
         end else if (pick == 5) begin
            v = rand64() >> $urandom_range(63);
            send_id(OP_BIN_TO_DEC, v);
         end else if (pick < 9) begin
            send_id(OP_DEC_TO_BIN, rand_dec());
         end else begin
            send_id(OP_DEC_TO_BIN, rand64());
         end
      end
   endtask

   task automatic run_phase(input int idle, input int stall, input int count);
      send_idle_pct = idle;
      recv_stall_pct = stall;
      test_random(count);
   endtask

   initial begin
      err_count = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      rsp_stall <= 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_bin_directed();
      test_dec_directed();
      run_phase(0, 0, 270);
      run_phase(49, 0, 270);
      run_phase(0, 49, 270);
      run_phase(9, 9, 270);
      req_valid <= 1'b0;
      recv_stall_pct = 0;
      while (conv_queue.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (err_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      #2ms;
      $display("TB_ERROR");
      $finish;
   end
endmodule

FILE: htm_id_level_and_decimal_convert_top.f
sv/htmc_pkg.sv
sv/htmc_dabble_stage.sv
sv/htm_id_level_and_decimal_convert_top.sv
sv/htmc_checker.sv
sim/tb.sv
